// ===== design/differential_drive_odometry_core_assert.svh =====
// Assertion macros used by the checker file of the odometry core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ddo_pkg.sv =====
package ddo_pkg;

    // Number of CORDIC micro-rotations, legal range 8 to 32.
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);

    localparam int CW     = 64;   // CORDIC x and y datapath width
    localparam int ZW     = 34;   // CORDIC angle accumulator width
    localparam int MUL_W  = 33;   // shared multiplier operand width
    localparam int PROD_W = 2 * MUL_W;

    localparam logic signed [31:0]   POS_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]   POS_MIN      = 32'sh8000_0000;
    localparam logic signed [CW-1:0] ONE_Q40      = 64'sh0000_0100_0000_0000;
    localparam logic signed [CW-1:0] GAIN_INV_Q30 = 64'sd652032874;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [56:0]   DIFF_LIMIT   = 57'sd68719476736;

    typedef enum logic [0:0] {
        REG_COUNT_SCALE        = 1'b0,
        REG_INV_DOUBLE_SPACING = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        ACT_SAMPLE   = 1'b0,
        ACT_SET_POSE = 1'b1
    } action_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_R,
        S_MUL_L,
        S_DIFF,
        S_MEAN,
        S_YHI,
        S_YSUM,
        S_VEC,
        S_FOLD,
        S_ROT,
        S_TRIG,
        S_XHI,
        S_XLO,
        S_XADD,
        S_XACC,
        S_YADD,
        S_YACC,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } cordic_ctrl_t;

    // Elementary angles atan(2^-i) as binary angles, full turn = 2^32.
    function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] idx);
        logic signed [ZW-1:0] val;
        case (idx)
            5'd0:    val = 34'sd536870912;
            5'd1:    val = 34'sd316933406;
            5'd2:    val = 34'sd167458907;
            5'd3:    val = 34'sd85004756;
            5'd4:    val = 34'sd42667331;
            5'd5:    val = 34'sd21354465;
            5'd6:    val = 34'sd10679838;
            5'd7:    val = 34'sd5340245;
            5'd8:    val = 34'sd2670163;
            5'd9:    val = 34'sd1335087;
            5'd10:   val = 34'sd667544;
            5'd11:   val = 34'sd333772;
            5'd12:   val = 34'sd166886;
            5'd13:   val = 34'sd83443;
            5'd14:   val = 34'sd41721;
            5'd15:   val = 34'sd20860;
            5'd16:   val = 34'sd10430;
            5'd17:   val = 34'sd5215;
            5'd18:   val = 34'sd2607;
            5'd19:   val = 34'sd1303;
            5'd20:   val = 34'sd651;
            5'd21:   val = 34'sd325;
            5'd22:   val = 34'sd162;
            5'd23:   val = 34'sd81;
            5'd24:   val = 34'sd40;
            5'd25:   val = 34'sd20;
            5'd26:   val = 34'sd10;
            5'd27:   val = 34'sd5;
            5'd28:   val = 34'sd2;
            5'd29:   val = 34'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== design/ddo_mul.sv =====
module ddo_mul (
    input  logic                                clk,
    input  logic signed [ddo_pkg::MUL_W-1:0]    a,
    input  logic signed [ddo_pkg::MUL_W-1:0]    b,
    output logic signed [ddo_pkg::PROD_W-1:0]   prod
);

    logic signed [ddo_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== design/ddo_cordic.sv =====
module ddo_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ddo_pkg::cordic_ctrl_t             ctrl,
    input  logic signed [ddo_pkg::CW-1:0]     x_init,
    input  logic signed [ddo_pkg::CW-1:0]     y_init,
    input  logic signed [ddo_pkg::ZW-1:0]     z_init,
    output logic                              done,
    output logic signed [ddo_pkg::CW-1:0]     x_res,
    output logic signed [ddo_pkg::CW-1:0]     y_res,
    output logic signed [ddo_pkg::ZW-1:0]     z_res
);

    logic                              busy_reg;
    logic                              done_reg;
    logic                              vec_reg;
    logic [ddo_pkg::ITER_W-1:0]        iter_reg;
    logic signed [ddo_pkg::CW-1:0]     x_reg;
    logic signed [ddo_pkg::CW-1:0]     y_reg;
    logic signed [ddo_pkg::ZW-1:0]     z_reg;

    logic signed [ddo_pkg::CW-1:0]     xs;
    logic signed [ddo_pkg::CW-1:0]     ys;
    logic signed [ddo_pkg::ZW-1:0]     angle;
    logic                              up;
    logic                              last;
    logic signed [ddo_pkg::CW-1:0]     x_next;
    logic signed [ddo_pkg::CW-1:0]     y_next;
    logic signed [ddo_pkg::ZW-1:0]     z_next;

    // In vectoring mode the sign of y steers the rotation, in rotation mode the
    // sign of the residual angle does; both reduce to the same add/sub pattern.
    always_comb
    begin
        xs     = x_reg >>> iter_reg;
        ys     = y_reg >>> iter_reg;
        angle  = ddo_pkg::atan_turn(5'(iter_reg));
        up     = vec_reg ? y_reg[ddo_pkg::CW-1] : !z_reg[ddo_pkg::ZW-1];
        last   = (iter_reg == ddo_pkg::ITER_W'(ddo_pkg::CORDIC_STEPS - 1));
        if (up)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - angle;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            vec_reg  <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                vec_reg  <= ctrl.vectoring;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign x_res = x_reg;
    assign y_res = y_reg;
    assign z_res = z_reg;

endmodule

// ===== design/differential_drive_odometry_core.sv =====
// Differential-drive wheel odometry core.
// Input channel (in_valid/in_ready): one transaction is either an encoder sample
// (absolute right and left counts) or a set-pose command that overwrites the
// x, y and heading components whose load bits are set.
// Output channel (out_valid/out_ready): exactly one transaction per input item
// carrying the pose after that item and a saturation flag.
// Configuration: cfg_write with cfg_index and cfg_data writes count_scale or
// inv_double_spacing; write only while the core is idle.
// An encoder sample runs through one shared 33x33 multiplier and one shared
// CORDIC unit, which makes a vectoring pass and then a rotation pass of
// CORDIC_STEPS micro-rotations each. A set-pose item goes from the idle
// state straight to the done state.
// in_ready is high only in the idle state, so a new item is taken the cycle
// after the previous result went to the output register.
// If the receiver stalls, the result is held in the output register and the
// core accepts one more item; that item waits at its last step until the
// output register is free.
// Reset clears the pose, the stored counts and the output valid, and loads
// count_scale = 65536 and inv_double_spacing = 83886.
module differential_drive_odometry_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic signed [31:0] encoder_right,
    input  logic signed [31:0] encoder_left,
    input  logic signed [31:0] new_x,
    input  logic signed [31:0] new_y,
    input  logic [31:0]        new_heading,
    input  logic               load_x,
    input  logic               load_y,
    input  logic               load_heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic [31:0]        heading_out,
    output logic               overflow
);

    ddo_pkg::seq_state_t state_reg, state_next;

    logic [23:0]        cs_reg;
    logic [23:0]        ids_reg;
    logic [31:0]        prev_r_reg;
    logic [31:0]        prev_l_reg;
    logic signed [31:0] x_acc_reg, x_acc_next;
    logic signed [31:0] y_acc_reg, y_acc_next;
    logic [31:0]        heading_reg, heading_next;
    logic               ov_reg, ov_next;
    logic               out_valid_reg;
    logic signed [31:0] x_out_reg;
    logic signed [31:0] y_out_reg;
    logic [31:0]        heading_out_reg;
    logic               overflow_reg;

    logic signed [31:0] dr_reg;
    logic signed [31:0] dl_reg;
    logic signed [55:0] inc_r_reg;
    logic signed [55:0] inc_l_reg;
    logic signed [37:0] diff_reg;
    logic signed [47:0] mean_reg;
    logic signed [ddo_pkg::PROD_W-1:0] part_reg;
    logic signed [49:0] term_reg;
    logic signed [ddo_pkg::MUL_W-1:0]  c_reg;
    logic signed [ddo_pkg::MUL_W-1:0]  s_reg;
    logic               flip_reg;

    logic                                 in_accept;
    logic                                 out_load;
    logic signed [ddo_pkg::MUL_W-1:0]     mul_a;
    logic signed [ddo_pkg::MUL_W-1:0]     mul_b;
    logic signed [ddo_pkg::PROD_W-1:0]    prod;
    ddo_pkg::cordic_ctrl_t                cordic_ctrl;
    logic signed [ddo_pkg::CW-1:0]        cx_init;
    logic signed [ddo_pkg::CW-1:0]        cy_init;
    logic signed [ddo_pkg::ZW-1:0]        cz_init;
    logic                                 cordic_done;
    logic signed [ddo_pkg::CW-1:0]        cx_res;
    logic signed [ddo_pkg::CW-1:0]        cy_res;
    logic signed [ddo_pkg::ZW-1:0]        cz_res;

    logic signed [56:0] diff_full;
    logic signed [37:0] diff_clamped;
    logic signed [56:0] wheel_sum;
    logic signed [79:0] move_sum;
    logic signed [50:0] x_sum;
    logic signed [50:0] y_sum;
    logic signed [31:0] head_s;
    logic               fold;
    logic signed [ddo_pkg::CW-1:0] cx_neg;
    logic signed [ddo_pkg::CW-1:0] cy_neg;
    logic signed [ddo_pkg::MUL_W-1:0] mean_hi;
    logic signed [ddo_pkg::MUL_W-1:0] mean_lo;

    ddo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ddo_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cordic_ctrl),
        .x_init (cx_init),
        .y_init (cy_init),
        .z_init (cz_init),
        .done   (cordic_done),
        .x_res  (cx_res),
        .y_res  (cy_res),
        .z_res  (cz_res)
    );

    assign in_ready  = (state_reg == ddo_pkg::S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == ddo_pkg::S_DONE) && (!out_valid_reg || out_ready);

    // Datapath helpers.
    always_comb
    begin
        diff_full = {inc_r_reg[55], inc_r_reg} - {prod[55], prod[55:0]};
        if (diff_full > ddo_pkg::DIFF_LIMIT)
            diff_clamped = ddo_pkg::DIFF_LIMIT[37:0];
        else if (diff_full < -ddo_pkg::DIFF_LIMIT)
            diff_clamped = 38'(-ddo_pkg::DIFF_LIMIT);
        else
            diff_clamped = diff_full[37:0];

        wheel_sum = {inc_r_reg[55], inc_r_reg} + {inc_l_reg[55], inc_l_reg};

        // Exact floor(mean * trig / 2^30) from the two partial products.
        move_sum = {part_reg[55:0], 24'b0} + {{14{prod[ddo_pkg::PROD_W-1]}}, prod};

        x_sum = {{19{x_acc_reg[31]}}, x_acc_reg} + {term_reg[49], term_reg};
        y_sum = {{19{y_acc_reg[31]}}, y_acc_reg} - {term_reg[49], term_reg};

        head_s = heading_reg;
        fold   = ($signed({{2{head_s[31]}}, head_s}) > ddo_pkg::QUARTER_TURN) ||
                 ($signed({{2{head_s[31]}}, head_s}) < -ddo_pkg::QUARTER_TURN);

        cx_neg = -cx_res;
        cy_neg = -cy_res;

        mean_hi = {{9{mean_reg[47]}}, mean_reg[47:24]};
        mean_lo = {9'b0, mean_reg[23:0]};
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ddo_pkg::S_MUL_R:
            begin
                mul_a = {dr_reg[31], dr_reg};
                mul_b = {9'b0, cs_reg};
            end
            ddo_pkg::S_MUL_L:
            begin
                mul_a = {dl_reg[31], dl_reg};
                mul_b = {9'b0, cs_reg};
            end
            ddo_pkg::S_MEAN:
            begin
                mul_a = {14'b0, diff_reg[18:0]};
                mul_b = {9'b0, ids_reg};
            end
            ddo_pkg::S_YHI:
            begin
                mul_a = {{14{diff_reg[37]}}, diff_reg[37:19]};
                mul_b = {9'b0, ids_reg};
            end
            ddo_pkg::S_XHI:
            begin
                mul_a = mean_hi;
                mul_b = c_reg;
            end
            ddo_pkg::S_XLO:
            begin
                mul_a = mean_lo;
                mul_b = c_reg;
            end
            ddo_pkg::S_XADD:
            begin
                mul_a = mean_hi;
                mul_b = s_reg;
            end
            ddo_pkg::S_XACC:
            begin
                mul_a = mean_lo;
                mul_b = s_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer: next state, pose updates and CORDIC control.
    always_comb
    begin
        state_next   = state_reg;
        x_acc_next   = x_acc_reg;
        y_acc_next   = y_acc_reg;
        heading_next = heading_reg;
        ov_next      = ov_reg;
        cordic_ctrl  = '0;
        cx_init      = ddo_pkg::ONE_Q40;
        cy_init      = (prod[ddo_pkg::CW-1:0] <<< 19) + part_reg[ddo_pkg::CW-1:0];
        cz_init      = '0;
        unique case (state_reg)
            ddo_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    ov_next = 1'b0;
                    if (ddo_pkg::action_t'(action) == ddo_pkg::ACT_SET_POSE)
                    begin
                        if (load_x)
                            x_acc_next = new_x;
                        if (load_y)
                            y_acc_next = new_y;
                        if (load_heading)
                            heading_next = new_heading;
                        state_next = ddo_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = ddo_pkg::S_MUL_R;
                    end
                end
            end
            ddo_pkg::S_MUL_R: state_next = ddo_pkg::S_MUL_L;
            ddo_pkg::S_MUL_L: state_next = ddo_pkg::S_DIFF;
            ddo_pkg::S_DIFF:  state_next = ddo_pkg::S_MEAN;
            ddo_pkg::S_MEAN:  state_next = ddo_pkg::S_YHI;
            ddo_pkg::S_YHI:   state_next = ddo_pkg::S_YSUM;
            ddo_pkg::S_YSUM:
            begin
                cordic_ctrl.start     = 1'b1;
                cordic_ctrl.vectoring = 1'b1;
                state_next            = ddo_pkg::S_VEC;
            end
            ddo_pkg::S_VEC:
            begin
                if (cordic_done)
                begin
                    heading_next = heading_reg + cz_res[31:0];
                    state_next   = ddo_pkg::S_FOLD;
                end
            end
            ddo_pkg::S_FOLD:
            begin
                // Headings beyond a quarter turn are rotated by a half turn and
                // the results negated afterwards.
                cordic_ctrl.start = 1'b1;
                cx_init           = ddo_pkg::GAIN_INV_Q30;
                cy_init           = '0;
                if (fold)
                    cz_init = {{2{~heading_reg[31]}}, ~heading_reg[31], heading_reg[30:0]};
                else
                    cz_init = {{2{heading_reg[31]}}, heading_reg};
                state_next = ddo_pkg::S_ROT;
            end
            ddo_pkg::S_ROT:
            begin
                if (cordic_done)
                    state_next = ddo_pkg::S_TRIG;
            end
            ddo_pkg::S_TRIG: state_next = ddo_pkg::S_XHI;
            ddo_pkg::S_XHI:  state_next = ddo_pkg::S_XLO;
            ddo_pkg::S_XLO:  state_next = ddo_pkg::S_XADD;
            ddo_pkg::S_XADD: state_next = ddo_pkg::S_XACC;
            ddo_pkg::S_XACC:
            begin
                if (x_sum > 51'(ddo_pkg::POS_MAX))
                begin
                    x_acc_next = ddo_pkg::POS_MAX;
                    ov_next    = 1'b1;
                end
                else if (x_sum < 51'(ddo_pkg::POS_MIN))
                begin
                    x_acc_next = ddo_pkg::POS_MIN;
                    ov_next    = 1'b1;
                end
                else
                begin
                    x_acc_next = x_sum[31:0];
                end
                state_next = ddo_pkg::S_YADD;
            end
            ddo_pkg::S_YADD: state_next = ddo_pkg::S_YACC;
            ddo_pkg::S_YACC:
            begin
                if (y_sum > 51'(ddo_pkg::POS_MAX))
                begin
                    y_acc_next = ddo_pkg::POS_MAX;
                    ov_next    = 1'b1;
                end
                else if (y_sum < 51'(ddo_pkg::POS_MIN))
                begin
                    y_acc_next = ddo_pkg::POS_MIN;
                    ov_next    = 1'b1;
                end
                else
                begin
                    y_acc_next = y_sum[31:0];
                end
                state_next = ddo_pkg::S_DONE;
            end
            ddo_pkg::S_DONE:
            begin
                if (out_load)
                    state_next = ddo_pkg::S_IDLE;
            end
            default: state_next = ddo_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ddo_pkg::S_IDLE;
            cs_reg        <= 24'd65536;
            ids_reg       <= 24'd83886;
            prev_r_reg    <= '0;
            prev_l_reg    <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            heading_reg   <= '0;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            x_acc_reg   <= x_acc_next;
            y_acc_reg   <= y_acc_next;
            heading_reg <= heading_next;
            ov_reg      <= ov_next;
            if (cfg_write)
            begin
                unique case (ddo_pkg::reg_index_t'(cfg_index))
                    ddo_pkg::REG_COUNT_SCALE:        cs_reg  <= cfg_data;
                    ddo_pkg::REG_INV_DOUBLE_SPACING: ids_reg <= cfg_data;
                    default:                         cs_reg  <= cs_reg;
                endcase
            end
            if (in_accept && (ddo_pkg::action_t'(action) == ddo_pkg::ACT_SAMPLE))
            begin
                prev_r_reg <= encoder_right;
                prev_l_reg <= encoder_left;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the datapath; they need no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dr_reg <= encoder_right - prev_r_reg;
            dl_reg <= encoder_left - prev_l_reg;
        end
        case (state_reg)
            ddo_pkg::S_MUL_L: inc_r_reg <= prod[55:0];
            ddo_pkg::S_DIFF:
            begin
                inc_l_reg <= prod[55:0];
                diff_reg  <= diff_clamped;
            end
            ddo_pkg::S_MEAN: mean_reg <= wheel_sum[56:9];
            ddo_pkg::S_YHI:  part_reg <= prod;
            ddo_pkg::S_FOLD: flip_reg <= fold;
            ddo_pkg::S_TRIG:
            begin
                c_reg <= flip_reg ? cx_neg[ddo_pkg::MUL_W-1:0] : cx_res[ddo_pkg::MUL_W-1:0];
                s_reg <= flip_reg ? cy_neg[ddo_pkg::MUL_W-1:0] : cy_res[ddo_pkg::MUL_W-1:0];
            end
            ddo_pkg::S_XLO:  part_reg <= prod;
            ddo_pkg::S_XADD: term_reg <= move_sum[79:30];
            ddo_pkg::S_XACC: part_reg <= prod;
            ddo_pkg::S_YADD: term_reg <= move_sum[79:30];
            default:         term_reg <= term_reg;
        endcase
        if (out_load)
        begin
            x_out_reg       <= x_acc_reg;
            y_out_reg       <= y_acc_reg;
            heading_out_reg <= heading_reg;
            overflow_reg    <= ov_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign x_out       = x_out_reg;
    assign y_out       = y_out_reg;
    assign heading_out = heading_out_reg;
    assign overflow    = overflow_reg;

endmodule

// ===== design/ddo_checker.sv =====
`include "differential_drive_odometry_core_assert.svh"

module ddo_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] x_out,
    input logic signed [31:0] y_out,
    input logic [31:0]        heading_out,
    input logic               overflow
);

    // The core works on one item at a time.
    `DDO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "core ready while busy")

    // A result only appears at the end of an item's processing.
    `DDO_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result without item")

    `DDO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(x_out) && $stable(y_out) && $stable(heading_out) && $stable(overflow), "stalled result changed")

    // The overflow flag always comes with a coordinate held at a bound.
    `DDO_ASSERT_SAME(a_overflow_saturated, out_valid && overflow, x_out == ddo_pkg::POS_MAX || x_out == ddo_pkg::POS_MIN || y_out == ddo_pkg::POS_MAX || y_out == ddo_pkg::POS_MIN, "overflow without saturation")

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (.*);
